### rtl/wstq_pkg.sv
package wstq_pkg;

	// command codes
	localparam logic CMD_SPAWN   = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// configuration register indexes
	localparam logic CFG_ACTIVE  = 1'b0;
	localparam logic CFG_RUNNING = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_OWN     = 3'd0,
		ST_STOLEN  = 3'd1,
		ST_WAIT    = 3'd2,
		ST_EXIT    = 3'd3,
		ST_QUEUED  = 3'd4,
		ST_DROPPED = 3'd5,
		ST_IGNORED = 3'd6
	} status_t;

	localparam logic [3:0] ACTIVE_RESET = 4'd4;

endpackage

### rtl/work_stealing_task_queues.sv
// work-stealing task dispatcher, one request per start, one result strobe per request
// ignored spawn, inactive-worker request: answered from idle; spawn: full check, write
// own pop: own check, read, read wait; steal: own check, victim scan, read, read wait
// nothing found ends the scan; one request at a time, the scan probing one queue per cycle
// reset: queues empty, spawn pointer 0, active_workers 4, scheduler_running 1
// the done strobe lasts one cycle and the receiver cannot stall it
module work_stealing_task_queues #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   start,
	output logic                   busy,
	input  logic                   command,
	input  logic [2:0]             worker_id,
	input  logic [HANDLE_BITS-1:0] task_handle,
	// configuration write port
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [3:0]             cfg_data,
	// result channel
	output logic                   done,
	output wstq_pkg::status_t      status,
	output logic [HANDLE_BITS-1:0] task_out,
	output logic [2:0]             source_queue
);

	import wstq_pkg::*;

	// widths
	localparam int NW  = $clog2(WORKERS + 1);               // holds the active count
	localparam int QW  = (WORKERS > 1) ? $clog2(WORKERS) : 1; // queue index
	localparam int XW  = (NW > 4) ? NW : 4;                  // compare width
	localparam int HW  = $clog2(QUEUE_DEPTH);                // head / slot index
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);            // fill count
	localparam int SW  = CW + 1;                             // slot sum
	localparam int MD  = WORKERS * QUEUE_DEPTH;
	localparam int AW  = $clog2(MD);

	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
	localparam logic [XW-1:0] WORKERS_X = XW'(WORKERS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPAWN_CHK,
		S_MEM_WR,
		S_OWN_CHK,
		S_SCAN,
		S_MEM_RD,
		S_RD_WAIT
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0] active_q;
	logic       running_q;

	// per-queue control state
	logic [HW-1:0] head_q  [WORKERS];
	logic [CW-1:0] count_q [WORKERS];
	logic [QW-1:0] spawn_ptr_q;

	// request context
	logic [HANDLE_BITS-1:0] handle_q;
	logic [QW-1:0]          sel_q;      // queue under work
	logic [HW-1:0]          pos_q;      // slot within that queue
	logic [NW-1:0]          n_q;        // active count latched at accept
	logic [NW-1:0]          step_q;     // victims probed so far
	logic                   steal_q;

	// result registers
	logic                   done_q;
	status_t                status_q;
	logic [HANDLE_BITS-1:0] task_q;
	logic [2:0]             src_q;

	// ram ports
	logic                   ram_we;
	logic                   ram_re;
	logic [AW-1:0]          ram_addr;
	logic [HANDLE_BITS-1:0] ram_rdata;

	// slot arithmetic: the modular add used by spawn, own pop and steal
	function automatic logic [HW-1:0] slot_wrap(input logic [HW-1:0] h,
		input logic [CW-1:0] c);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(c);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return HW'(s);
	endfunction

	// active count clamped into 1..WORKERS
	logic [XW-1:0] act_x;
	logic [NW-1:0] n_now;

	always_comb begin
		act_x = XW'(active_q);
		if (act_x == '0) begin
			n_now = NW'(1);
		end else if (act_x > WORKERS_X) begin
			n_now = NW'(WORKERS);
		end else begin
			n_now = NW'(act_x);
		end
	end

	// spawn target, a stale pointer acts as queue 0
	logic [QW-1:0] spawn_q_sel;
	logic [QW-1:0] spawn_ptr_next;
	logic          id_active;

	always_comb begin
		spawn_q_sel = (XW'(spawn_ptr_q) < XW'(n_now)) ? spawn_ptr_q : '0;
		spawn_ptr_next = (XW'(spawn_q_sel) + XW'(1) >= XW'(n_now)) ? '0
			: QW'(XW'(spawn_q_sel) + XW'(1));
		id_active = (XW'(worker_id) < XW'(n_now));
	end

	// selected queue state, read at one address per cycle
	logic [HW-1:0] sel_head;
	logic [CW-1:0] sel_count;
	logic [QW-1:0] sel_next;    // next victim, wrapping at the active count
	logic          scan_last;

	always_comb begin
		sel_head  = head_q[sel_q];
		sel_count = count_q[sel_q];
		sel_next  = (XW'(sel_q) + XW'(1) >= XW'(n_q)) ? '0 : QW'(XW'(sel_q) + XW'(1));
		scan_last = (XW'(step_q) + XW'(1) >= XW'(n_q));
	end

	// ram address: queue base plus slot
	assign ram_we   = (state_q == S_MEM_WR);
	assign ram_re   = (state_q == S_MEM_RD);
	assign ram_addr = AW'(sel_q) * DEPTH_A + AW'(pos_q);

	wstq_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (MD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (handle_q),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RESET;
			running_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE:  active_q  <= cfg_data;
				CFG_RUNNING: running_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			spawn_ptr_q <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_WAIT;
			task_q      <= '0;
			src_q       <= '0;
			sel_q       <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			step_q      <= '0;
			steal_q     <= 1'b0;
			handle_q    <= '0;
			for (int i = 0; i < WORKERS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						handle_q <= task_handle;
						n_q      <= n_now;
						if (command == CMD_SPAWN) begin
							if (task_handle == '0) begin
								// null handle, nothing queued
								done_q   <= 1'b1;
								status_q <= ST_IGNORED;
								task_q   <= '0;
								src_q    <= '0;
							end else begin
								sel_q       <= spawn_q_sel;
								spawn_ptr_q <= spawn_ptr_next;
								state_q     <= S_SPAWN_CHK;
							end
						end else if (id_active) begin
							sel_q   <= QW'(worker_id);
							state_q <= S_OWN_CHK;
						end else begin
							// inactive worker touches no queue
							done_q   <= 1'b1;
							status_q <= running_q ? ST_WAIT : ST_EXIT;
							task_q   <= '0;
							src_q    <= '0;
						end
					end
				end

				S_SPAWN_CHK: begin
					if (sel_count >= DEPTH_C) begin
						done_q   <= 1'b1;
						status_q <= ST_DROPPED;
						task_q   <= '0;
						src_q    <= 3'(sel_q);
						state_q  <= S_IDLE;
					end else begin
						pos_q          <= slot_wrap(sel_head, sel_count);
						count_q[sel_q] <= sel_count + CW'(1);
						state_q        <= S_MEM_WR;
					end
				end

				S_MEM_WR: begin
					done_q   <= 1'b1;
					status_q <= ST_QUEUED;
					task_q   <= '0;
					src_q    <= 3'(sel_q);
					state_q  <= S_IDLE;
				end

				S_OWN_CHK: begin
					if (sel_count != '0) begin
						// pop the front of the worker's own queue
						pos_q          <= sel_head;
						head_q[sel_q]  <= slot_wrap(sel_head, CW'(1));
						count_q[sel_q] <= sel_count - CW'(1);
						steal_q        <= 1'b0;
						state_q        <= S_MEM_RD;
					end else if (n_q == NW'(1)) begin
						done_q   <= 1'b1;
						status_q <= running_q ? ST_WAIT : ST_EXIT;
						task_q   <= '0;
						src_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						sel_q   <= sel_next;
						step_q  <= NW'(1);
						state_q <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (sel_count != '0) begin
						// steal from the back of this victim
						pos_q          <= slot_wrap(sel_head, sel_count - CW'(1));
						count_q[sel_q] <= sel_count - CW'(1);
						steal_q        <= 1'b1;
						state_q        <= S_MEM_RD;
					end else if (scan_last) begin
						done_q   <= 1'b1;
						status_q <= running_q ? ST_WAIT : ST_EXIT;
						task_q   <= '0;
						src_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						sel_q  <= sel_next;
						step_q <= step_q + NW'(1);
					end
				end

				S_MEM_RD: begin
					state_q <= S_RD_WAIT;
				end

				S_RD_WAIT: begin
					done_q   <= 1'b1;
					status_q <= steal_q ? ST_STOLEN : ST_OWN;
					task_q   <= ram_rdata;
					src_q    <= 3'(sel_q);
					state_q  <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign task_out     = task_q;
	assign source_queue = src_q;

endmodule

### rtl/wstq_ram.sv
module wstq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### bench/work_stealing_task_queues_tb.sv
module work_stealing_task_queues_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wstq_pkg::*;

	localparam int WORKERS     = 8;
	localparam int DEPTH       = 16;
	localparam int HBITS       = 16;
	// items and gaps are short: this is many times the slowest run
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 140;
	localparam int MAX_PRINTS  = 100;

	// one result as the block should give it
	typedef struct {
		status_t           status;
		logic [HBITS-1:0]  task_h;
		logic [2:0]        src;
	} dispatch_result_t;

	// mirror of the queues plus the results still owed by the block
	class dispatch_scoreboard;
		dispatch_result_t awaited[$];
		logic [HBITS-1:0] slots [WORKERS][DEPTH];
		logic [3:0]       front [WORKERS];
		logic [4:0]       fill [WORKERS];
		logic [2:0]       spawn_ptr;
		logic [3:0]       active_workers;
		logic             running;
		int               errors;

		function new();
			for (int q = 0; q < WORKERS; q++) begin
				front[q] = '0;
				fill[q]  = '0;
				for (int e = 0; e < DEPTH; e++)
					slots[q][e] = '0;
			end
			spawn_ptr      = '0;
			active_workers = ACTIVE_RESET;
			running        = 1'b1;
			errors         = 0;
		endfunction

		function void configure(logic idx, logic [3:0] val);
			if (idx == CFG_ACTIVE)
				active_workers = val;
			else
				running = val[0];
		endfunction

		// one request in, the queue update and the expected answer out
		function dispatch_result_t dispatch(logic cmd, logic [2:0] id, logic [HBITS-1:0] h);
			dispatch_result_t r;
			int n;
			int q;
			int v;
			int pos;
			n = int'(active_workers);
			if (n < 1)
				n = 1;
			if (n > WORKERS)
				n = WORKERS;
			if (running)
				r.status = ST_WAIT;
			else
				r.status = ST_EXIT;
			r.task_h = '0;
			r.src    = '0;
			if (cmd == CMD_SPAWN) begin
				if (h == '0) begin
					r.status = ST_IGNORED;
					return r;
				end
				// stale pointer falls back to queue 0
				q = (int'(spawn_ptr) < n) ? int'(spawn_ptr) : 0;
				spawn_ptr = (q + 1 >= n) ? 3'd0 : 3'(q + 1);
				r.src = 3'(q);
				if (int'(fill[q]) >= DEPTH) begin
					r.status = ST_DROPPED;
					return r;
				end
				pos = (int'(front[q]) + int'(fill[q])) % DEPTH;
				slots[q][pos] = h;
				fill[q] = fill[q] + 5'd1;
				r.status = ST_QUEUED;
				return r;
			end
			if (int'(id) < n) begin
				if (fill[id] != '0) begin
					r.task_h  = slots[id][front[id]];
					front[id] = 4'((int'(front[id]) + 1) % DEPTH);
					fill[id]  = fill[id] - 5'd1;
					r.status  = ST_OWN;
					r.src     = id;
					return r;
				end
				for (int i = 1; i < n; i++) begin
					v = (int'(id) + i) % n;
					if (fill[v] != '0) begin
						pos = (int'(front[v]) + int'(fill[v]) - 1) % DEPTH;
						fill[v]  = fill[v] - 5'd1;
						r.task_h = slots[v][pos];
						r.status = ST_STOLEN;
						r.src    = 3'(v);
						return r;
					end
				end
			end
			return r;
		endfunction

		function void note(logic cmd, logic [2:0] id, logic [HBITS-1:0] h);
			awaited.insert(awaited.size(), dispatch(cmd, id, h));
		endfunction

		task flag(string msg);
			if (errors < MAX_PRINTS)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(status_t st, logic [HBITS-1:0] t, logic [2:0] src);
			dispatch_result_t e;
			if (awaited.size() == 0) begin
				flag($sformatf("result with no request waiting, status %0d", st));
				return;
			end
			e = awaited[0];
			awaited.delete(0);
			if (st !== e.status)
				flag($sformatf("status %0d, wanted %0d", st, e.status));
			if (t !== e.task_h)
				flag($sformatf("task_out %h, wanted %h", t, e.task_h));
			if (src !== e.src)
				flag($sformatf("source_queue %0d, wanted %0d", src, e.src));
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             command;
	logic [2:0]       worker_id;
	logic [HBITS-1:0] task_handle;
	logic             cfg_we;
	logic             cfg_index;
	logic [3:0]       cfg_data;
	logic             done;
	status_t          status;
	logic [HBITS-1:0] task_out;
	logic [2:0]       source_queue;

	dispatch_scoreboard sb;
	int cycles;

	work_stealing_task_queues #(
		.WORKERS(WORKERS),
		.QUEUE_DEPTH(DEPTH),
		.HANDLE_BITS(HBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.worker_id(worker_id),
		.task_handle(task_handle),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.task_out(task_out),
		.source_queue(source_queue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on a stuck handshake or a missing result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("work_stealing_task_queues regression: fail");
			$finish;
		end
	end

	// every done strobe is checked against the oldest request still owed
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(status, task_out, source_queue);
	end

	// one request: optional idle cycles first, then hold start until busy is low at an edge
	task automatic send(logic cmd, logic [2:0] id, logic [HBITS-1:0] h, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		worker_id   <= id;
		task_handle <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note(cmd, id, h);
	endtask

	// sender stops until every owed result has come and the block is free
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
	endtask

	// both registers in back-to-back cycles, enable held high across them
	task automatic write_regs(logic [3:0] act, logic run);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ACTIVE;
		cfg_data  <= act;
		@(posedge clk);
		sb.configure(CFG_ACTIVE, act);
		cfg_index <= CFG_RUNNING;
		cfg_data  <= {3'b000, run};
		@(posedge clk);
		sb.configure(CFG_RUNNING, {3'b000, run});
		cfg_we    <= 1'b0;
	endtask

	initial begin
		// phase table: active count, running, sender idle percent, spawn percent
		int act [PHASES]   = '{8, 1, 0, 15, 3, 2, 8, 5, 1, 8};
		int run [PHASES]   = '{1, 1, 1, 0, 1, 0, 1, 1, 0, 0};
		int idle [PHASES]  = '{0, 75, 27, 0, 75, 27, 0, 27, 75, 0};
		int spawn [PHASES] = '{60, 80, 40, 50, 70, 30, 35, 65, 20, 50};
		logic             cmd;
		logic [2:0]       id;
		logic [HBITS-1:0] h;

		sb = new();
		cycles = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		command     <= CMD_SPAWN;
		worker_id   <= 3'd0;
		task_handle <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_ACTIVE;
		cfg_data    <= 4'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, on the reset configuration (4 workers, running)
		send(CMD_REQUEST, 3'd0, '0, 0);         // empty everywhere: wait
		send(CMD_REQUEST, 3'd7, '0, 0);         // worker beyond active count
		send(CMD_SPAWN, 3'd0, '0, 0);           // null handle ignored
		send(CMD_SPAWN, 3'd5, 16'hFFFF, 0);     // queue 0
		send(CMD_SPAWN, 3'd0, 16'h0001, 0);     // queue 1
		send(CMD_SPAWN, 3'd0, 16'h8000, 0);     // queue 2
		send(CMD_REQUEST, 3'd0, 16'hFFFF, 0);   // own pop
		send(CMD_REQUEST, 3'd3, '0, 0);         // steal past empty queue 0
		send(CMD_REQUEST, 3'd1, '0, 0);         // steal from queue 2
		send(CMD_REQUEST, 3'd2, '0, 0);         // nothing left
		drain();
		// shutdown: idle workers exit, spawns still land
		write_regs(4'd4, 1'b0);
		send(CMD_REQUEST, 3'd0, '0, 0);
		send(CMD_SPAWN, 3'd0, 16'h1234, 0);
		send(CMD_REQUEST, 3'd5, '0, 0);
		send(CMD_REQUEST, 3'd0, '0, 0);
		send(CMD_SPAWN, 3'd2, '0, 0);
		drain();

		// random phases: spawn-heavy ones fill queues to the drop point,
		// request-heavy ones drain and steal, shrinking counts strand tasks
		for (int p = 0; p < PHASES; p++) begin
			write_regs(4'(act[p]), run[p][0]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				cmd = ($urandom_range(0, 99) < spawn[p]) ? CMD_SPAWN : CMD_REQUEST;
				id  = 3'($urandom_range(0, 7));
				h   = ($urandom_range(0, 15) == 0) ? '0 : HBITS'($urandom_range(1, 65535));
				send(cmd, id, h, idle[p]);
				// hold-off until the block has answered everything
				if (p == 4 && k == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		repeat (2 * WORKERS + 4) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag($sformatf("%0d results never came", sb.pending()));
		if (sb.errors == 0)
			$display("work_stealing_task_queues regression: pass");
		else
			$display("work_stealing_task_queues regression: fail");
		$finish;
	end

endmodule
